// ===== design/assert_macros.svh =====
// Assertion macros shared by the decoder RTL files.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define U8D_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define U8D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/u8d_pkg.sv =====
// Shared types and constants of the UTF-8 to code point decoder.
// No dependencies; imported by every other design file but assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    localparam int BYTE_W        = 8;
    localparam int CP_W          = 21;
    localparam int MAX_SEQ_BYTES = 4;
    localparam int WIN_AW        = $clog2(MAX_SEQ_BYTES);
    localparam int CNT_W         = WIN_AW + 1;
    localparam int QDEPTH        = 4;
    localparam int QAW           = $clog2(QDEPTH);
    localparam int QCW           = QAW + 1;

    localparam logic [CP_W-1:0] REPLACEMENT = CP_W'(21'h00FFFD);

    // Sequence length announced by a byte when it leads the window
    typedef enum logic [1:0] {
        LEN1 = 2'd0,
        LEN2 = 2'd1,
        LEN3 = 2'd2,
        LEN4 = 2'd3
    } t_len;

    // One queued byte with its lead class
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_len              len;
    } t_tok;

endpackage

`default_nettype wire

// ===== design/u8d_byte_if.sv =====
// Byte input channel: valid/ready handshake carrying one raw byte.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface u8d_byte_if import u8d_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== design/u8d_rune_if.sv =====
// Code point output channel: valid/ready handshake carrying one rune.
// Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface u8d_rune_if import u8d_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic            last_of_run;

    modport source (output valid, output code_point, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== design/u8d_fifo.sv =====
// Short token queue between the decoder front end and back end.
// Depends on u8d_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module u8d_fifo import u8d_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_tok i_tok,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_tok      o_tok
);

    t_tok           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0] r_count,  n_count;

    assign o_full  = (r_count == QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd_ptr];

    // pointer and fill-level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QAW'(QDEPTH - 1)) ? '0 : r_wr_ptr + QAW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QAW'(QDEPTH - 1)) ? '0 : r_rd_ptr + QAW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    `U8D_ASSERT(a_fifo_level, i_clk, i_rst_n, r_count <= QCW'(QDEPTH), "fifo overfilled")

endmodule

`default_nettype wire

// ===== design/u8d_front.sv =====
// Front end: accepts raw bytes, tags each with its lead-length class, queues it.
// Depends on u8d_pkg, u8d_byte_if and u8d_fifo.
`timescale 1ns / 1ps
`default_nettype none

module u8d_front import u8d_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    u8d_byte_if.sink   i_byte,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_tok       o_tok
);

    logic q_full;
    logic push;
    t_tok tok;

    assign i_byte.ready = !q_full;
    assign push         = i_byte.valid && !q_full;

    // classify by lead byte range
    always_comb begin
        tok.data = i_byte.data_byte;
        if (i_byte.data_byte < 8'hC0) begin
            tok.len = LEN1;
        end else if (i_byte.data_byte < 8'hE0) begin
            tok.len = LEN2;
        end else if (i_byte.data_byte < 8'hF0) begin
            tok.len = LEN3;
        end else begin
            tok.len = LEN4;
        end
    end

    u8d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (tok),
        .o_full  (q_full),
        .i_pop   (i_pop),
        .o_valid (o_valid),
        .o_tok   (o_tok)
    );

endmodule

`default_nettype wire

// ===== design/u8d_back.sv =====
// Back end: byte window, one decode step per cycle while the output is not stalled, result holding and output register.
// Depends on u8d_pkg, u8d_rune_if and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module u8d_back import u8d_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_tok  i_tok,
    output logic       o_pop,
    u8d_rune_if.source o_rune
);

    typedef struct packed {
        logic            ok;
        logic [CP_W-1:0] cp;
    } t_dec;

    // decode a full window of the given length
    function automatic t_dec dec_win(input t_tok w0, input t_tok w1,
                                     input t_tok w2, input t_tok w3);
        t_dec             d;
        logic [CP_W-1:0]  v;
        logic             c1, c2, c3;
        c1   = (w1.data[7:6] == 2'b10);
        c2   = (w2.data[7:6] == 2'b10);
        c3   = (w3.data[7:6] == 2'b10);
        d.ok = 1'b0;
        d.cp = '0;
        case (w0.len)
            LEN1: begin
                d.ok = !w0.data[7];
                d.cp = CP_W'(w0.data);
            end
            LEN2: begin
                v    = CP_W'({w0.data[4:0], w1.data[5:0]});
                d.ok = c1 && (v > CP_W'(21'h7F));
                d.cp = v;
            end
            LEN3: begin
                v    = CP_W'({w0.data[3:0], w1.data[5:0], w2.data[5:0]});
                d.ok = c1 && c2 && (v > CP_W'(21'h7FF));
                d.cp = v;
            end
            LEN4: begin
                v    = {w0.data[2:0], w1.data[5:0], w2.data[5:0], w3.data[5:0]};
                d.ok = c1 && c2 && c3 && !w0.data[3]
                       && (v > CP_W'(21'hFFFF)) && (v <= CP_W'(21'h10FFFF));
                d.cp = v;
            end
            default: begin
                d.ok = 1'b0;
            end
        endcase
        return d;
    endfunction

    t_tok             r_win [MAX_SEQ_BYTES];
    t_tok             n_win [MAX_SEQ_BYTES];
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             r_busy, n_busy;
    logic             r_hold_vld, n_hold_vld;
    logic [CP_W-1:0]  r_hold_cp,  n_hold_cp;
    logic             r_out_vld,  n_out_vld;
    logic [CP_W-1:0]  r_out_cp,   n_out_cp;
    logic             r_out_last, n_out_last;

    t_dec             dec;
    logic [CNT_W-1:0] need;
    logic [CNT_W-1:0] used;
    logic [CP_W-1:0]  res_cp;
    logic             run_end;
    logic             emit_new;
    logic             out_free;

    assign o_rune.valid       = r_out_vld;
    assign o_rune.code_point  = r_out_cp;
    assign o_rune.last_of_run = r_out_last;

    // current decode step on the window head
    assign dec      = dec_win(r_win[0], r_win[1], r_win[2], r_win[3]);
    assign need     = CNT_W'(r_win[0].len) + CNT_W'(1);
    assign run_end  = (r_cnt < need);
    assign used     = dec.ok ? need : CNT_W'(1);
    assign res_cp   = dec.ok ? dec.cp : REPLACEMENT;
    assign emit_new = !run_end && (res_cp != '0);
    assign out_free = !r_out_vld || o_rune.ready;
    assign o_pop    = !r_busy && i_valid;

    // window, holding slot and output register control
    always_comb begin
        logic [CNT_W-1:0] src;
        n_win      = r_win;
        n_cnt      = r_cnt;
        n_busy     = r_busy;
        n_hold_vld = r_hold_vld;
        n_hold_cp  = r_hold_cp;
        n_out_vld  = r_out_vld && !o_rune.ready;
        n_out_cp   = r_out_cp;
        n_out_last = r_out_last;
        src        = '0;
        if (!r_busy) begin
            // append the next queued byte to the window
            if (i_valid) begin
                n_win[r_cnt[WIN_AW-1:0]] = i_tok;
                n_cnt  = r_cnt + CNT_W'(1);
                n_busy = 1'b1;
            end
        end else if (run_end) begin
            // window incomplete: close the run, flag the held rune as last
            if (!r_hold_vld) begin
                n_busy = 1'b0;
            end else if (out_free) begin
                n_out_vld  = 1'b1;
                n_out_cp   = r_hold_cp;
                n_out_last = 1'b1;
                n_hold_vld = 1'b0;
                n_busy     = 1'b0;
            end
        end else if (!(emit_new && r_hold_vld && !out_free)) begin
            // one decode step: consume bytes, pass any new rune to the holding slot
            if (emit_new) begin
                if (r_hold_vld) begin
                    n_out_vld  = 1'b1;
                    n_out_cp   = r_hold_cp;
                    n_out_last = 1'b0;
                end
                n_hold_vld = 1'b1;
                n_hold_cp  = res_cp;
            end
            for (int i = 0; i < MAX_SEQ_BYTES; i++) begin
                src = CNT_W'(i) + used;
                if (src < CNT_W'(MAX_SEQ_BYTES)) begin
                    n_win[i] = r_win[src[WIN_AW-1:0]];
                end
            end
            n_cnt = r_cnt - used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_busy     <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_cnt      <= n_cnt;
            r_busy     <= n_busy;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_win      <= n_win;
        r_hold_cp  <= n_hold_cp;
        r_out_cp   <= n_out_cp;
        r_out_last <= n_out_last;
    end

    `U8D_ASSERT(a_idle_cnt, i_clk, i_rst_n, !r_busy |-> r_cnt < CNT_W'(MAX_SEQ_BYTES), "idle window too full")
    `U8D_ASSERT(a_idle_hold, i_clk, i_rst_n, !r_busy |-> !r_hold_vld, "rune held outside a run")
    `U8D_ASSERT(a_run_start, i_clk, i_rst_n, $rose(r_busy) |-> r_cnt != '0, "run started on empty window")

endmodule

`default_nettype wire

// ===== design/utf8_stream_to_rune_decoder.sv =====
// Top level of the UTF-8 byte stream to code point decoder.
// Depends on u8d_pkg, u8d_byte_if, u8d_rune_if, u8d_front and u8d_back.
//
//  channel   dir   payload                       width
//  i_byte    in    data_byte                     8
//  o_rune    out   code_point, last_of_run       21, 1
//
// In the back end a byte is appended to the window (load), then decode steps consume
// complete sequences from the window head, an invalid head being dropped byte by byte,
// and the run is closed once the window is incomplete; the next byte is taken only then.
// Reset is synchronous and clears the queue, window count and valid flags; no sweep.
// A four-entry queue keeps taking bytes until it is full while the output register waits on o_rune.ready.
// NUL and incomplete windows produce no rune; last_of_run marks a byte's final rune.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_to_rune_decoder import u8d_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    u8d_byte_if.sink   i_byte,
    u8d_rune_if.source o_rune
);

    logic q_valid;
    logic q_pop;
    t_tok q_tok;

    u8d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_tok   (q_tok)
    );

    u8d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_tok   (q_tok),
        .o_pop   (q_pop),
        .o_rune  (o_rune)
    );

endmodule

`default_nettype wire
